// ===== rtl/pbm_pkg.sv =====
package pbm_pkg;

  // pool geometry
  localparam int PIECE_BYTES          = 128;
  localparam int MAX_PIECES_PER_BLOCK = 16;
  localparam int NUM_PIECES           = 256;
  localparam int NUM_BLOCKS           = 8;

  localparam int OFF_W    = $clog2(PIECE_BYTES);
  localparam int PIECE_W  = $clog2(NUM_PIECES);
  localparam int KIDX_W   = $clog2(MAX_PIECES_PER_BLOCK);
  localparam int SLOT_W   = $clog2(NUM_BLOCKS);
  localparam int LIST_AW  = SLOT_W + KIDX_W;
  localparam int DATA_AW  = PIECE_W + OFF_W;
  localparam int LIST_DEPTH = NUM_BLOCKS * MAX_PIECES_PER_BLOCK;
  localparam int DATA_DEPTH = NUM_PIECES * PIECE_BYTES;
  localparam int BLOCK_CAP  = PIECE_BYTES * MAX_PIECES_PER_BLOCK;
  localparam int CNT_W      = KIDX_W + 1;

  // transaction field widths
  localparam int REQ_W    = 2;
  localparam int ID_W     = 3;
  localparam int BYTE_W   = 8;
  localparam int BOFF_W   = 11;
  localparam int STATUS_W = 3;
  localparam int LEN_W    = 12;
  localparam int FC_W     = 9;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [REQ_W-1:0] {
    OP_OPEN    = 2'd0,
    OP_PUT     = 2'd1,
    OP_READ    = 2'd2,
    OP_RELEASE = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_STATE   = 3'd1,
    ST_FULL    = 3'd2,
    ST_NOPIECE = 3'd3,
    ST_RANGE   = 3'd4
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic [BYTE_W-1:0] data;
    logic [BOFF_W-1:0] off;
  } cmd_t;

endpackage

// ===== rtl/pbm_req_if.sv =====
interface pbm_req_if import pbm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ID_W-1:0]   block_id;
  logic [BYTE_W-1:0] data_byte;
  logic [BOFF_W-1:0] byte_offset;

  modport source (output valid, req_type, block_id, data_byte, byte_offset, input ready);
  modport sink   (input valid, req_type, block_id, data_byte, byte_offset, output ready);
endinterface

// ===== rtl/pbm_rsp_if.sv =====
interface pbm_rsp_if import pbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   read_data;
  logic [LEN_W-1:0]    block_length;
  logic [FC_W-1:0]     free_pieces;

  modport source (output valid, status, read_data, block_length, free_pieces, input ready);
  modport sink   (input valid, status, read_data, block_length, free_pieces, output ready);
endinterface

// ===== rtl/pbm_cfg_if.sv =====
interface pbm_cfg_if import pbm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [FC_W-1:0] pool_pieces;

  modport source (output valid, pool_pieces, input ready);
  modport sink   (input valid, pool_pieces, output ready);
endinterface

// ===== rtl/piece_pool_buffer_manager.sv =====
// channel  | dir | handshake     | payload
// req_i    | in  | valid / ready | req_type, block_id, data_byte, byte_offset
// rsp_o    | out | valid / ready | status, read_data, block_length, free_pieces
// cfg_i    | in  | valid / ready | pool_pieces
//
// open, rejects and early status answers come from the idle state; put passes S_PUT,
// read S_RD_LIST, S_RD_DATA (piece list read, then data read), release S_REL per piece.
// the executor starts a request only when the result register is free or
// being drained; a 2-entry command queue keeps accepting meanwhile until full.
// reset gives a full pool of 256 pieces, all blocks closed; no clearing pass.
// a pool_pieces write re-initializes the pool.
module piece_pool_buffer_manager import pbm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pbm_req_if.sink    req_i,
  pbm_rsp_if.source  rsp_o,
  pbm_cfg_if.sink    cfg_i
);

  logic push, full, pop, q_valid;
  cmd_t push_cmd, q_cmd;

  // request decode
  pbm_front u_front (
    .req    (req_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  // command queue
  pbm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // executor
  pbm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (pop),
    .cfg       (cfg_i),
    .rsp       (rsp_o)
  );

endmodule

// ===== rtl/pbm_front.sv =====
module pbm_front import pbm_pkg::*; (
  pbm_req_if.sink req,
  input  logic    full_i,
  output logic    push_o,
  output cmd_t    cmd_o
);

  // accept whenever the queue has room
  assign req.ready = !full_i;
  assign push_o    = req.valid && !full_i;

  // classify the request into a command
  always_comb begin
    cmd_o.op   = op_e'(req.req_type);
    cmd_o.slot = req.block_id[SLOT_W-1:0];
    cmd_o.data = req.data_byte;
    cmd_o.off  = req.byte_offset;
  end

endmodule

// ===== rtl/pbm_queue.sv =====
module pbm_queue import pbm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
    end
  end

endmodule

// ===== rtl/pbm_back.sv =====
module pbm_back import pbm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  cmd_t     q_cmd_i,
  output logic     q_pop_o,
  pbm_cfg_if.sink  cfg,
  pbm_rsp_if.source rsp
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_PUT     = 3'd1;
  localparam logic [2:0] S_RD_LIST = 3'd2;
  localparam logic [2:0] S_RD_DATA = 3'd3;
  localparam logic [2:0] S_REL     = 3'd4;

  logic [2:0] state_q, state_d;
  cmd_t       cmd_q, cmd_d;

  logic [NUM_BLOCKS-1:0] open_q, open_d;
  logic [LEN_W-1:0]      len_q [NUM_BLOCKS];
  logic [LEN_W-1:0]      len_d [NUM_BLOCKS];
  logic [CNT_W-1:0]      cnt_q [NUM_BLOCKS];
  logic [CNT_W-1:0]      cnt_d [NUM_BLOCKS];
  logic [PIECE_W-1:0]    take_q, take_d, ret_q, ret_d;
  logic [FC_W-1:0]       fc_q, fc_d;
  logic [CNT_W-1:0]      rel_q, rel_d;
  logic [NUM_PIECES-1:0] ring_vld_q;

  // memories
  logic [PIECE_W-1:0] ring_mem [NUM_PIECES];
  logic [PIECE_W-1:0] list_mem [LIST_DEPTH];
  logic [BYTE_W-1:0]  data_mem [DATA_DEPTH];

  logic               ring_we, list_we, data_we;
  logic [PIECE_W-1:0] ring_waddr, ring_wdata, ring_rd_q;
  logic [LIST_AW-1:0] list_waddr, list_raddr;
  logic [PIECE_W-1:0] list_wdata, list_rd_q;
  logic [DATA_AW-1:0] data_waddr, data_raddr;
  logic [BYTE_W-1:0]  data_wdata, data_rd_q;

  logic                out_vld_q, out_vld_d;
  status_e             out_st_q, out_st_d;
  logic [BYTE_W-1:0]   out_rd_q, out_rd_d;
  logic [LEN_W-1:0]    out_len_q, out_len_d;
  logic [FC_W-1:0]     out_fc_q, out_fc_d;

  cmd_t               cur;
  logic [LEN_W-1:0]   len;
  logic               emit;
  status_e            st;
  logic [BYTE_W-1:0]  rdv;
  logic [PIECE_W-1:0] piece;
  logic [CNT_W-1:0]   rel_nxt;
  logic [FC_W-1:0]    pool_n;
  logic               out_free;
  logic               cfg_wr;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid;
  assign pool_n    = (cfg.pool_pieces > FC_W'(NUM_PIECES)) ? FC_W'(NUM_PIECES)
                                                           : cfg.pool_pieces;

  assign out_free  = !out_vld_q || rsp.ready;
  assign cur       = (state_q == S_IDLE) ? q_cmd_i : cmd_q;
  assign len       = len_q[cur.slot];

  // request sequencer
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    open_d     = open_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    take_d     = take_q;
    ret_d      = ret_q;
    fc_d       = fc_q;
    rel_d      = rel_q;
    q_pop_o    = 1'b0;
    emit       = 1'b0;
    st         = ST_OK;
    rdv        = '0;
    piece      = '0;
    rel_nxt    = rel_q + 1'b1;
    ring_we    = 1'b0;
    ring_waddr = ret_q;
    ring_wdata = list_rd_q;
    list_we    = 1'b0;
    list_waddr = {cur.slot, len[OFF_W +: KIDX_W]};
    list_wdata = '0;
    list_raddr = '0;
    data_we    = 1'b0;
    data_waddr = '0;
    data_wdata = cur.data;
    data_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free && !cfg_wr) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          if (cur.op == OP_OPEN) begin
            emit = 1'b1;
            if (open_q[cur.slot]) begin
              st = ST_STATE;
            end else begin
              open_d[cur.slot] = 1'b1;
              len_d[cur.slot]  = '0;
              cnt_d[cur.slot]  = '0;
            end
          end else if (!open_q[cur.slot]) begin
            emit = 1'b1;
            st   = ST_STATE;
          end else begin
            unique case (cur.op)
              OP_PUT: begin
                list_raddr = {cur.slot, len[OFF_W +: KIDX_W]};
                if (len >= LEN_W'(BLOCK_CAP)) begin
                  emit = 1'b1;
                  st   = ST_FULL;
                end else if (len[OFF_W-1:0] == '0 && fc_q == '0) begin
                  emit = 1'b1;
                  st   = ST_NOPIECE;
                end else begin
                  state_d = S_PUT;
                end
              end
              OP_READ: begin
                list_raddr = {cur.slot, cur.off[OFF_W +: KIDX_W]};
                if (LEN_W'(cur.off) >= len) begin
                  emit = 1'b1;
                  st   = ST_RANGE;
                end else begin
                  state_d = S_RD_LIST;
                end
              end
              default: begin
                list_raddr = {cur.slot, KIDX_W'(0)};
                if (cnt_q[cur.slot] == '0) begin
                  emit             = 1'b1;
                  open_d[cur.slot] = 1'b0;
                  len_d[cur.slot]  = '0;
                end else begin
                  rel_d   = '0;
                  state_d = S_REL;
                end
              end
            endcase
          end
        end
      end

      // append one byte, taking a new piece at a piece boundary
      S_PUT: begin
        if (len[OFF_W-1:0] == '0) begin
          piece      = ring_vld_q[take_q] ? ring_rd_q : take_q;
          list_we    = 1'b1;
          list_wdata = piece;
          take_d     = take_q + 1'b1;
          fc_d       = fc_q - 1'b1;
          cnt_d[cur.slot] = cnt_q[cur.slot] + 1'b1;
        end else begin
          piece = list_rd_q;
        end
        data_we         = 1'b1;
        data_waddr      = {piece, len[OFF_W-1:0]};
        len_d[cur.slot] = len + 1'b1;
        emit            = 1'b1;
        state_d         = S_IDLE;
      end

      S_RD_LIST: begin
        data_raddr = {list_rd_q, cur.off[OFF_W-1:0]};
        state_d    = S_RD_DATA;
      end

      S_RD_DATA: begin
        rdv     = data_rd_q;
        emit    = 1'b1;
        state_d = S_IDLE;
      end

      // hand one piece back to the ring per cycle
      S_REL: begin
        ring_we = 1'b1;
        ret_d   = ret_q + 1'b1;
        if (fc_q < FC_W'(NUM_PIECES)) begin
          fc_d = fc_q + 1'b1;
        end
        rel_d      = rel_nxt;
        list_raddr = {cur.slot, rel_nxt[KIDX_W-1:0]};
        if (rel_nxt == cnt_q[cur.slot]) begin
          open_d[cur.slot] = 1'b0;
          len_d[cur.slot]  = '0;
          cnt_d[cur.slot]  = '0;
          emit             = 1'b1;
          state_d          = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // pool re-initialization
    if (cfg_wr) begin
      open_d  = '0;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        len_d[i] = '0;
        cnt_d[i] = '0;
      end
      take_d  = '0;
      ret_d   = pool_n[PIECE_W-1:0];
      fc_d    = pool_n;
      state_d = S_IDLE;
    end
  end

  // result register
  always_comb begin
    out_vld_d = out_vld_q && !rsp.ready;
    out_st_d  = out_st_q;
    out_rd_d  = out_rd_q;
    out_len_d = out_len_q;
    out_fc_d  = out_fc_q;
    if (emit) begin
      out_vld_d = 1'b1;
      out_st_d  = st;
      out_rd_d  = rdv;
      out_len_d = len_d[cur.slot];
      out_fc_d  = fc_d;
    end
  end

  assign rsp.valid        = out_vld_q;
  assign rsp.status       = out_st_q;
  assign rsp.read_data    = out_rd_q;
  assign rsp.block_length = out_len_q;
  assign rsp.free_pieces  = out_fc_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      open_q     <= '0;
      take_q     <= '0;
      ret_q      <= '0;
      fc_q       <= FC_W'(NUM_PIECES);
      rel_q      <= '0;
      ring_vld_q <= '0;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        len_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      open_q    <= open_d;
      len_q     <= len_d;
      cnt_q     <= cnt_d;
      take_q    <= take_d;
      ret_q     <= ret_d;
      fc_q      <= fc_d;
      rel_q     <= rel_d;
      out_vld_q <= out_vld_d;
      if (cfg_wr) begin
        ring_vld_q <= '0;
      end else if (ring_we) begin
        ring_vld_q[ring_waddr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    out_st_q  <= out_st_d;
    out_rd_q  <= out_rd_d;
    out_len_q <= out_len_d;
    out_fc_q  <= out_fc_d;
  end

  // free ring
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    ring_rd_q <= ring_mem[take_q];
  end

  // per-block piece lists
  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    list_rd_q <= list_mem[list_raddr];
  end

  // piece data
  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    data_rd_q <= data_mem[data_raddr];
  end

endmodule

// ===== verif/tb_piece_pool_buffer_manager.sv =====
`timescale 1ns / 100ps

module tb_piece_pool_buffer_manager;
  import pbm_pkg::*;

  // one expected result of the block
  typedef struct {
    status_e          st;
    logic [BYTE_W-1:0] rdata;
    logic [LEN_W-1:0]  len;
    logic [FC_W-1:0]   fc;
  } pool_result_t;

  // shadow of the buffer pool, predicts each result
  class pool_scoreboard;
    logic [7:0]        data_mem [DATA_DEPTH];
    logic [7:0]        ring [NUM_PIECES];
    logic [7:0]        piece_list [LIST_DEPTH];
    int unsigned       take_pos, ret_pos, free_cnt;
    bit                is_open [NUM_BLOCKS];
    int unsigned       blen [NUM_BLOCKS];
    int unsigned       npieces [NUM_BLOCKS];
    pool_result_t      pending [$];
    int                errors;

    function void init_pool(int unsigned pieces);
      int unsigned n;
      n = (pieces > NUM_PIECES) ? NUM_PIECES : pieces;
      for (int i = 0; i < NUM_PIECES; i++) ring[i] = 8'(i);
      take_pos = 0;
      ret_pos  = n % NUM_PIECES;
      free_cnt = n;
      for (int s = 0; s < NUM_BLOCKS; s++) begin
        is_open[s] = 0;
        blen[s]    = 0;
        npieces[s] = 0;
      end
    endfunction

    function int unsigned data_addr(int unsigned s, int unsigned pos);
      int unsigned p;
      p = piece_list[s*MAX_PIECES_PER_BLOCK + pos/PIECE_BYTES];
      return p*PIECE_BYTES + pos % PIECE_BYTES;
    endfunction

    // note an accepted request and queue its expected result
    function void note_request(op_e op, int unsigned s, logic [7:0] b, int unsigned off);
      pool_result_t r;
      r.st = ST_OK;
      r.rdata = '0;
      case (op)
        OP_OPEN: begin
          if (is_open[s]) r.st = ST_STATE;
          else begin
            is_open[s] = 1;
            blen[s] = 0;
            npieces[s] = 0;
          end
        end
        OP_PUT: begin
          if (!is_open[s]) r.st = ST_STATE;
          else if (blen[s] >= BLOCK_CAP) r.st = ST_FULL;
          else if (blen[s] % PIECE_BYTES == 0 && free_cnt == 0) r.st = ST_NOPIECE;
          else begin
            if (blen[s] % PIECE_BYTES == 0) begin
              piece_list[s*MAX_PIECES_PER_BLOCK + npieces[s]] = ring[take_pos];
              take_pos = (take_pos + 1) % NUM_PIECES;
              free_cnt--;
              npieces[s]++;
            end
            data_mem[data_addr(s, blen[s])] = b;
            blen[s]++;
          end
        end
        OP_READ: begin
          if (!is_open[s]) r.st = ST_STATE;
          else if (off >= blen[s]) r.st = ST_RANGE;
          else r.rdata = data_mem[data_addr(s, off)];
        end
        default: begin
          if (!is_open[s]) r.st = ST_STATE;
          else begin
            for (int i = 0; i < npieces[s]; i++) begin
              ring[ret_pos] = piece_list[s*MAX_PIECES_PER_BLOCK + i];
              ret_pos = (ret_pos + 1) % NUM_PIECES;
              if (free_cnt < NUM_PIECES) free_cnt++;
            end
            is_open[s] = 0;
            blen[s] = 0;
            npieces[s] = 0;
          end
        end
      endcase
      r.len = LEN_W'(blen[s]);
      r.fc  = FC_W'(free_cnt);
      pending.push_back(r);
    endfunction

    // compare one response with the oldest expectation
    function void check_response(logic [STATUS_W-1:0] st, logic [7:0] rd,
                                 logic [LEN_W-1:0] len, logic [FC_W-1:0] fc);
      pool_result_t r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response st=%0d", st);
        return;
      end
      r = pending.pop_front();
      if (st !== r.st || rd !== r.rdata || len !== r.len || fc !== r.fc) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp st=%0d rd=%0d len=%0d fc=%0d got st=%0d rd=%0d len=%0d fc=%0d",
                   r.st, r.rdata, r.len, r.fc, st, rd, len, fc);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;

  pbm_req_if req_if ();
  pbm_rsp_if rsp_if ();
  pbm_cfg_if cfg_if ();

  piece_pool_buffer_manager u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source),
    .cfg_i  (cfg_if.sink)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  pool_scoreboard sb;
  int  hold_cycles;
  int  stall_mode;
  bit  done;
  int  gap_max;

  initial begin
    req_if.valid = 0;
    req_if.req_type = '0;
    req_if.block_id = '0;
    req_if.data_byte = '0;
    req_if.byte_offset = '0;
    cfg_if.valid = 0;
    cfg_if.pool_pieces = '0;
    rsp_if.ready = 0;
    hold_cycles = 0;
    stall_mode = 0;
    done = 0;
  end

  // response side: stalls on its own pattern, long hold-off on request
  always @(posedge clk_i) begin
    if (rsp_if.valid && rsp_if.ready)
      sb.check_response(rsp_if.status, rsp_if.read_data, rsp_if.block_length,
                        rsp_if.free_pieces);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp_if.ready <= 0;
    end else if (stall_mode == 0) rsp_if.ready <= 1;
    else rsp_if.ready <= ($urandom_range(0, 3) != 0);
  end

  // send one request, accepted when ready is seen high
  task automatic send_req(op_e op, int unsigned s, logic [7:0] b, int unsigned off);
    req_if.valid <= 1;
    req_if.req_type <= op;
    req_if.block_id <= ID_W'(s);
    req_if.data_byte <= b;
    req_if.byte_offset <= BOFF_W'(off);
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(op, s, b, off);
  endtask

  task automatic idle_req(int n);
    req_if.valid <= 0;
    repeat (n) @(posedge clk_i);
  endtask

  // random gaps between bursts
  task automatic maybe_gap();
    if (gap_max > 0 && $urandom_range(0, 7) == 0) idle_req($urandom_range(1, gap_max));
  endtask

  task automatic drain();
    idle_req(1);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_pool(int unsigned pieces);
    cfg_if.valid <= 1;
    cfg_if.pool_pieces <= FC_W'(pieces);
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.init_pool(pieces);
    cfg_if.valid <= 0;
    @(posedge clk_i);
  endtask

  task automatic random_req();
    int unsigned s, k;
    s = $urandom_range(0, NUM_BLOCKS-1);
    k = $urandom_range(0, 99);
    if (k < 5) send_req(OP_OPEN, s, 0, $urandom);
    else if (k < 60) send_req(OP_PUT, s, 8'($urandom), $urandom);
    else if (k < 93) begin
      // mostly in range, sometimes beyond
      if (sb.blen[s] > 0 && $urandom_range(0, 5) != 0)
        send_req(OP_READ, s, 8'($urandom), $urandom_range(0, sb.blen[s]-1));
      else send_req(OP_READ, s, 8'($urandom), $urandom_range(0, 2047));
    end else send_req(OP_RELEASE, s, 8'($urandom), $urandom);
    maybe_gap();
  endtask

  initial begin
    sb = new();
    sb.init_pool(256);
    gap_max = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: rejects, open, extremes, piece boundaries
    send_req(OP_PUT, 0, 8'hff, 0);
    send_req(OP_READ, 7, 0, 2047);
    send_req(OP_RELEASE, 3, 0, 0);
    send_req(OP_OPEN, 0, 0, 0);
    send_req(OP_OPEN, 0, 0, 0);
    send_req(OP_READ, 0, 0, 0);
    send_req(OP_PUT, 0, 8'h00, 0);
    send_req(OP_PUT, 0, 8'hff, 11'h7ff);
    send_req(OP_READ, 0, 0, 1);
    send_req(OP_READ, 0, 0, 0);
    send_req(OP_READ, 0, 0, 2047);
    send_req(OP_OPEN, 7, 0, 0);
    for (int i = 0; i < 2*PIECE_BYTES + 1; i++) send_req(OP_PUT, 7, 8'(i), 0);
    send_req(OP_READ, 7, 0, 2047);
    send_req(OP_READ, 7, 0, 2*PIECE_BYTES);
    send_req(OP_RELEASE, 7, 0, 0);
    send_req(OP_RELEASE, 0, 0, 0);
    drain();

    // one-piece pool: exhaustion
    write_pool(1);
    send_req(OP_OPEN, 1, 0, 0);
    send_req(OP_OPEN, 2, 0, 0);
    send_req(OP_PUT, 1, 8'h5a, 0);
    send_req(OP_PUT, 2, 8'ha5, 0);
    send_req(OP_RELEASE, 1, 0, 0);
    send_req(OP_PUT, 2, 8'ha5, 0);
    send_req(OP_READ, 2, 0, 0);
    drain();

    // random phases across pool sizes
    for (int ph = 0; ph < 5; ph++) begin
      int unsigned sz;
      case (ph)
        0: sz = 511;
        1: sz = 0;
        2: sz = 3;
        3: sz = 256;
        default: sz = $urandom_range(1, 255);
      endcase
      write_pool(sz);
      stall_mode = ph % 2;
      gap_max = (ph == 3) ? 0 : 6;
      for (int s = 0; s < NUM_BLOCKS; s++) send_req(OP_OPEN, s, 0, 0);
      if (ph == 2) hold_cycles = 200;
      for (int n = 0; n < 240; n++) random_req();
      if (ph == 1) begin
        // pause until all answers are in
        idle_req(1);
        while (sb.pending.size() != 0) @(posedge clk_i);
        for (int n = 0; n < 20; n++) random_req();
      end
      drain();
    end
    done = 1;
  end

  initial begin
    wait (done);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
